// File: rtl/core/bmhq_pkg.sv
// ---------------------------------------------------------------------------
// bmhq_pkg: shared types and constants of the binary min-heap queue
// Sizes, key and slot types, operation codes and the structs passed
// between the heap level cells and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int KEY_WIDTH = 32;
  // slots are numbered 1..CAPACITY; one level per bit of the slot number
  localparam int SLOT_W    = $clog2(CAPACITY + 1);
  localparam int LEVELS    = SLOT_W;
  localparam int LVL_W     = $clog2(LEVELS);

  typedef logic signed [KEY_WIDTH-1:0] key_t;
  typedef logic [SLOT_W-1:0]           slot_t;
  typedef logic [LVL_W-1:0]            lvl_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_POPPED    = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_INS_FULL  = 2'd3
  } status_e;

  // work item walking down the chain of level cells
  typedef struct packed {
    logic  valid;
    op_e   op;
    key_t  carry;  // key being placed at or below slot
    key_t  node;   // current content of slot (insert only)
    slot_t slot;   // slot on this level
    slot_t count;  // entries held after the operation
    slot_t path;   // insert: remaining path bits, next branch at the top
  } token_t;

  typedef struct packed {
    logic  en;
    slot_t slot;
    key_t  key;
  } wr_req_t;

endpackage

// File: rtl/core/bmhq_ram.sv
// ---------------------------------------------------------------------------
// bmhq_ram: simple dual-port key memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_ram #(
  parameter int  DEPTH = 2,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  bmhq_pkg::key_t      wr_data_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output bmhq_pkg::key_t      rd_data_o
);

  bmhq_pkg::key_t mem [DEPTH];
  bmhq_pkg::key_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/bmhq_cell.sv
// ---------------------------------------------------------------------------
// bmhq_cell: one heap level
// Takes a token, fetches the two children from the level below, rewrites
// its own slot and hands the token on, or finishes the operation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmhq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmhq_pkg::token_t   tok_i,
  input  bmhq_pkg::key_t     kid_even_i,
  input  bmhq_pkg::key_t     kid_odd_i,
  output bmhq_pkg::slot_t    rd_slot_o,
  output bmhq_pkg::wr_req_t  wr_o,
  output bmhq_pkg::token_t   tok_o,
  output logic               done_o
);

  bmhq_pkg::token_t tok_q;
  bmhq_pkg::token_t nxt;
  bmhq_pkg::token_t tok_out_q;
  bmhq_pkg::key_t   wr_key;
  bmhq_pkg::key_t   best;
  logic [bmhq_pkg::SLOT_W:0] left;
  logic [bmhq_pkg::SLOT_W:0] cnt;
  logic has_l, has_r, swap, dir, move, fin;
  logic done_q;

  // children row address goes out as the token arrives
  assign rd_slot_o = tok_i.slot;

  always_comb begin
    left   = {tok_q.slot, 1'b0};
    cnt    = {1'b0, tok_q.count};
    has_l  = (left <= cnt);
    has_r  = (left < cnt);
    nxt    = tok_q;
    wr_key = tok_q.carry;
    best   = tok_q.carry;
    swap   = 1'b0;
    dir    = 1'b0;
    move   = 1'b0;
    fin    = 1'b0;
    case (tok_q.op)
      bmhq_pkg::OP_INSERT: begin
        if (tok_q.slot == tok_q.count) begin
          fin = 1'b1;
        end else begin
          // keep the smaller key here, push the larger one down the path
          swap      = $signed(tok_q.carry) < $signed(tok_q.node);
          wr_key    = swap ? tok_q.carry : tok_q.node;
          nxt.carry = swap ? tok_q.node : tok_q.carry;
          dir       = tok_q.path[bmhq_pkg::SLOT_W-1];
          nxt.node  = dir ? kid_odd_i : kid_even_i;
          nxt.path  = tok_q.path << 1;
          move      = 1'b1;
        end
      end
      bmhq_pkg::OP_POP: begin
        if (has_l && ($signed(kid_even_i) < $signed(best))) begin
          best = kid_even_i;
          move = 1'b1;
          dir  = 1'b0;
        end
        if (has_r && ($signed(kid_odd_i) < $signed(best))) begin
          best = kid_odd_i;
          move = 1'b1;
          dir  = 1'b1;
        end
        if (move) begin
          wr_key = best;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
    nxt.slot  = {tok_q.slot[bmhq_pkg::SLOT_W-2:0], dir};
    nxt.valid = tok_q.valid & move;
  end

  assign wr_o.en   = tok_q.valid;
  assign wr_o.slot = tok_q.slot;
  assign wr_o.key  = wr_key;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      tok_out_q <= '0;
      done_q    <= 1'b0;
    end else begin
      tok_q     <= tok_i;
      tok_out_q <= nxt;
      done_q    <= tok_q.valid & fin;
    end
  end

  assign tok_o  = tok_out_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/binary_min_heap_queue.sv
// ---------------------------------------------------------------------------
// binary_min_heap_queue: priority queue of signed keys on a binary min-heap
// One transfer in gives one transfer out. An insert places the key on its
// way down from the root to the next free slot; a pop returns the root,
// takes the last entry and sifts it down toward the smaller child. The heap
// is a chain of level cells, one per level, each with its level's keys in
// two memories (even and odd children) and the root in a register; a
// token walks down the chain level by level (child read, then compare and
// write). An insert walks down to the new slot; a pop first fetches the
// last entry and then walks as far as the moved entry sinks. A pop leaves
// the heap one slot shorter. A pop on an empty heap or on a heap of one,
// and an insert into a full heap, go straight to their result without
// walking the chain. The input side takes one item at a time and is
// stalled until its result sits in the output register; the next item is
// taken while that result waits. A pop on an empty heap and an insert into
// a full one report their status and leave the heap untouched. The key
// memories need no clearing after reset: only slots already written are
// ever used.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_min_heap_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic signed [31:0]         key_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [31:0]         popped_key_o,
  output logic [1:0]                 status_o,
  output logic [10:0]                entry_count_o
);

  localparam int LEVELS = bmhq_pkg::LEVELS;
  localparam int SLOT_W = bmhq_pkg::SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_SIFT,
    S_RESP
  } state_e;

  state_e               state_q, state_d;
  bmhq_pkg::slot_t      count_q, count_d;
  bmhq_pkg::key_t       root_q;
  bmhq_pkg::token_t     launch_q, launch_d;
  bmhq_pkg::slot_t      last_q, last_d;
  bmhq_pkg::lvl_t       last_lvl_q, last_lvl_d;
  bmhq_pkg::key_t       res_key_q, res_key_d;
  bmhq_pkg::status_e    res_status_q, res_status_d;
  logic                 out_valid_q;
  bmhq_pkg::key_t       out_key_q;
  bmhq_pkg::status_e    out_status_q;
  bmhq_pkg::slot_t      out_count_q;

  bmhq_pkg::token_t     tok      [LEVELS];
  bmhq_pkg::slot_t      rd_slot  [LEVELS-1];
  bmhq_pkg::wr_req_t    wr       [LEVELS];
  bmhq_pkg::key_t       rd_even  [1:LEVELS-1];
  bmhq_pkg::key_t       rd_odd   [1:LEVELS-1];
  logic [LEVELS-1:0]    done_vec;

  bmhq_pkg::key_t       fetch_key;
  bmhq_pkg::slot_t      new_cnt;
  bmhq_pkg::lvl_t       new_lvl;
  logic                 fetch_en;
  logic                 out_free;

  // level of a slot: index of its highest set bit
  function automatic bmhq_pkg::lvl_t slot_level(input bmhq_pkg::slot_t s);
    bmhq_pkg::lvl_t r;
    r = '0;
    for (int i = 0; i < SLOT_W; i++) begin
      if (s[i]) begin
        r = bmhq_pkg::lvl_t'(i);
      end
    end
    return r;
  endfunction

  assign tok[0]   = launch_q;
  assign fetch_en = (state_q == S_FETCH);

  // ---- chain of level cells ------------------------------------------
  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    if (k < LEVELS - 1) begin : g_mid
      bmhq_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .tok_i      (tok[k]),
        .kid_even_i (rd_even[k+1]),
        .kid_odd_i  (rd_odd[k+1]),
        .rd_slot_o  (rd_slot[k]),
        .wr_o       (wr[k]),
        .tok_o      (tok[k+1]),
        .done_o     (done_vec[k])
      );
    end else begin : g_last
      // no level below the last one: children never exist
      bmhq_cell u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .tok_i      (tok[k]),
        .kid_even_i ('0),
        .kid_odd_i  ('0),
        .rd_slot_o  (),
        .wr_o       (wr[k]),
        .tok_o      (),
        .done_o     (done_vec[k])
      );
    end
  end

  // ---- level memories ---------------------------------------------------
  // Level l holds 2^l keys as 2^(l-1) rows of an even and an odd child.
  // The row of a key is its slot without the top bit and without the
  // lowest bit; the lowest bit picks the half.
  for (genvar l = 1; l < LEVELS; l++) begin : g_lvl
    localparam int RowW = (l > 1) ? l - 1 : 1;
    logic [RowW-1:0] wr_row;
    logic [RowW-1:0] rd_row;
    logic            fetch_sel;

    assign fetch_sel = fetch_en && (last_lvl_q == bmhq_pkg::lvl_t'(l));

    if (l == 1) begin : g_single
      assign wr_row = 1'b0;
      assign rd_row = 1'b0;
    end else begin : g_rows
      assign wr_row = wr[l].slot[l-1:1];
      // fetch of the last entry takes the read port while cells are idle
      assign rd_row = fetch_sel ? last_q[l-1:1] : rd_slot[l-1][l-2:0];
    end

    bmhq_ram #(.DEPTH(2 ** (l - 1))) u_even (
      .clk_i     (clk_i),
      .wr_en_i   (wr[l].en & ~wr[l].slot[0]),
      .wr_addr_i (wr_row),
      .wr_data_i (wr[l].key),
      .rd_addr_i (rd_row),
      .rd_data_o (rd_even[l])
    );

    bmhq_ram #(.DEPTH(2 ** (l - 1))) u_odd (
      .clk_i     (clk_i),
      .wr_en_i   (wr[l].en & wr[l].slot[0]),
      .wr_addr_i (wr_row),
      .wr_data_i (wr[l].key),
      .rd_addr_i (rd_row),
      .rd_data_o (rd_odd[l])
    );
  end

  // pick the fetched last entry from its level
  always_comb begin
    fetch_key = '0;
    for (int l = 1; l < LEVELS; l++) begin
      if (last_lvl_q == bmhq_pkg::lvl_t'(l)) begin
        fetch_key = last_q[0] ? rd_odd[l] : rd_even[l];
      end
    end
  end

  // root slot lives in a register, written by the first cell
  always_ff @(posedge clk_i) begin
    if (wr[0].en) begin
      root_q <= wr[0].key;
    end
  end

  // ---- control ----------------------------------------------------------
  assign out_free = !out_valid_q || !out_stall_i;
  assign new_cnt  = count_q + bmhq_pkg::slot_t'(1);
  assign new_lvl  = slot_level(new_cnt);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    launch_d     = launch_q;
    launch_d.valid = 1'b0;
    last_d       = last_q;
    last_lvl_d   = last_lvl_q;
    res_key_d    = res_key_q;
    res_status_d = res_status_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_key_d = '0;
          if (action_i == bmhq_pkg::OP_INSERT) begin
            if (count_q == bmhq_pkg::slot_t'(bmhq_pkg::CAPACITY)) begin
              res_status_d = bmhq_pkg::ST_INS_FULL;
              state_d      = S_RESP;
            end else begin
              // walk from the root toward the new slot
              res_status_d   = bmhq_pkg::ST_INSERTED;
              count_d        = new_cnt;
              launch_d.valid = 1'b1;
              launch_d.op    = bmhq_pkg::OP_INSERT;
              launch_d.carry = key_i;
              launch_d.node  = root_q;
              launch_d.slot  = bmhq_pkg::slot_t'(1);
              launch_d.count = new_cnt;
              launch_d.path  = new_cnt << (SLOT_W - int'(new_lvl));
              state_d        = S_SIFT;
            end
          end else begin
            if (count_q == '0) begin
              res_status_d = bmhq_pkg::ST_POP_EMPTY;
              state_d      = S_RESP;
            end else begin
              res_status_d = bmhq_pkg::ST_POPPED;
              res_key_d    = root_q;
              count_d      = count_q - bmhq_pkg::slot_t'(1);
              last_d       = count_q;
              last_lvl_d   = slot_level(count_q);
              // a heap of one simply empties
              state_d      = (count_q == bmhq_pkg::slot_t'(1)) ? S_RESP : S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        // last entry moves to the root and sifts down
        launch_d.valid = 1'b1;
        launch_d.op    = bmhq_pkg::OP_POP;
        launch_d.carry = fetch_key;
        launch_d.node  = '0;
        launch_d.slot  = bmhq_pkg::slot_t'(1);
        launch_d.count = count_q;
        launch_d.path  = '0;
        state_d        = S_SIFT;
      end
      S_SIFT: begin
        if (|done_vec) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      launch_q     <= '0;
      last_q       <= '0;
      last_lvl_q   <= '0;
      res_key_q    <= '0;
      res_status_q <= bmhq_pkg::ST_INSERTED;
      out_valid_q  <= 1'b0;
      out_key_q    <= '0;
      out_status_q <= bmhq_pkg::ST_INSERTED;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      launch_q     <= launch_d;
      last_q       <= last_d;
      last_lvl_q   <= last_lvl_d;
      res_key_q    <= res_key_d;
      res_status_q <= res_status_d;
      // output register: load a finished result, drop it once taken
      if (state_q == S_RESP && out_free) begin
        out_valid_q  <= 1'b1;
        out_key_q    <= res_key_q;
        out_status_q <= res_status_q;
        out_count_q  <= count_q;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign popped_key_o  = out_key_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;

endmodule
